>>> rtl/mcfe_pkg.sv
// Shared constants, register and operation codes, and controller/datapath
// command and status types for the multichannel FIR equalizer.
// No dependencies.
`timescale 1ns / 1ps

package mcfe_pkg;

	localparam int MAX_TAPS           = 2048;
	localparam int MAX_CHANNELS       = 8;
	localparam int SAMPLE_BITS        = 24;
	localparam int TAP_BITS           = 24;
	localparam int TAP_FRACTION_BITS  = 22;
	localparam int CHANNEL_BITS       = 3;
	localparam int TAP_INDEX_BITS     = 11;
	localparam int TAP_COUNT_BITS     = 12;
	localparam int CHANNEL_COUNT_BITS = 4;
	localparam int CFG_INDEX_BITS     = 1;
	localparam int CFG_DATA_BITS      = 12;
	localparam int IN_DATA_BITS       = 64;
	localparam int OUT_DATA_BITS      = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TAP  = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT     = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'b1;

	localparam logic [TAP_COUNT_BITS-1:0]     TAP_COUNT_RESET     = 12'd2048;
	localparam logic [CHANNEL_COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 4'd2;

	typedef struct packed {
		logic clear_en;
		logic capture;
		logic tap_write;
		logic push_write;
		logic mac_issue;
		logic load_out;
	} mcfe_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_tap;
		logic chan_ok;
		logic last_issue;
		logic pipe_busy;
		logic out_free;
	} mcfe_stat_t;

endpackage

>>> rtl/multichannel_fir_equalizer.sv
// Multichannel direct-form FIR equalizer: top level with stream ports.
// Each sample is accepted only in the idle state: a new sample waits until the
// previous result is loaded, and the single shared MAC sweeps the taps in use;
// a coefficient write or an ignored push returns to idle without a MAC sweep.
// Reset: asynchronous; a clearing pass over all MAX_CHANNELS * MAX_TAPS history
// entries (16384 by default) zeroes taps and history with s_axis_tready low.
`timescale 1ns / 1ps

module multichannel_fir_equalizer #(
	parameter int MAX_TAPS     = mcfe_pkg::MAX_TAPS,
	parameter int MAX_CHANNELS = mcfe_pkg::MAX_CHANNELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// channel[2:0], sample[26:3], tap_index[37:27], tap_value[61:38], zero pad
	input  logic [mcfe_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
	// opcode[0]
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// filtered[23:0], out_channel[26:24], zero pad
	output logic [mcfe_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [mcfe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mcfe_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int SB = mcfe_pkg::SAMPLE_BITS;
	localparam int CB = mcfe_pkg::CHANNEL_BITS;

	mcfe_pkg::mcfe_cmd_t  cmd;
	mcfe_pkg::mcfe_stat_t stat;

	logic signed [SB-1:0] filtered;
	logic [CB-1:0]        out_channel;

	mcfe_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mcfe_datapath #(
		.MAX_TAPS     (MAX_TAPS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_opcode    (s_axis_tuser),
		.in_channel   (s_axis_tdata[2:0]),
		.in_sample    (s_axis_tdata[26:3]),
		.in_tap_index (s_axis_tdata[37:27]),
		.in_tap_value (s_axis_tdata[61:38]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_filtered (filtered),
		.out_channel  (out_channel)
	);

	assign m_axis_tdata = {{(mcfe_pkg::OUT_DATA_BITS - SB - CB){1'b0}}, out_channel, filtered};

endmodule

>>> rtl/mcfe_controller.sv
// Sequencing state machine for the multichannel FIR equalizer.
// Depends on mcfe_pkg for the command and status types.
`timescale 1ns / 1ps

module mcfe_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcfe_pkg::mcfe_stat_t stat,
	output mcfe_pkg::mcfe_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_MAC    = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (stat.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_tap) begin
					cmd.tap_write = 1'b1;
					state_next    = ST_IDLE;
				end else if (!stat.chan_ok) begin
					state_next = ST_IDLE;
				end else begin
					cmd.push_write = 1'b1;
					state_next     = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (stat.last_issue) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	a_push_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_write |=> cmd.mac_issue)
		else $error("push did not start the tap sweep");

	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!stat.pipe_busy && stat.out_free))
		else $error("result loaded while products in flight or output busy");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pipe_busy)
		else $error("accepting while products in flight");

endmodule

>>> rtl/mcfe_datapath.sv
// Datapath of the multichannel FIR equalizer: config registers, tap and
// history memories, multiply-accumulate pipeline and output register.
// Depends on mcfe_pkg for constants, codes and command/status types.
`timescale 1ns / 1ps

module mcfe_datapath #(
	parameter int MAX_TAPS     = mcfe_pkg::MAX_TAPS,
	parameter int MAX_CHANNELS = mcfe_pkg::MAX_CHANNELS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mcfe_pkg::mcfe_cmd_t                      cmd,
	output mcfe_pkg::mcfe_stat_t                     stat,
	input  logic                                     in_opcode,
	input  logic [mcfe_pkg::CHANNEL_BITS-1:0]        in_channel,
	input  logic signed [mcfe_pkg::SAMPLE_BITS-1:0]  in_sample,
	input  logic [mcfe_pkg::TAP_INDEX_BITS-1:0]      in_tap_index,
	input  logic signed [mcfe_pkg::TAP_BITS-1:0]     in_tap_value,
	input  logic                                     cfg_we,
	input  logic [mcfe_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [mcfe_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [mcfe_pkg::SAMPLE_BITS-1:0]  out_filtered,
	output logic [mcfe_pkg::CHANNEL_BITS-1:0]        out_channel
);

	localparam int SB         = mcfe_pkg::SAMPLE_BITS;
	localparam int TB         = mcfe_pkg::TAP_BITS;
	localparam int FB         = mcfe_pkg::TAP_FRACTION_BITS;
	localparam int CB         = mcfe_pkg::CHANNEL_BITS;
	localparam int IB         = mcfe_pkg::TAP_INDEX_BITS;
	localparam int TAP_AW     = $clog2(MAX_TAPS);
	localparam int TCNT_W     = $clog2(MAX_TAPS + 1);
	localparam int CH_AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CCNT_W     = $clog2(MAX_CHANNELS + 1);
	localparam int HIST_DEPTH = MAX_CHANNELS * MAX_TAPS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int PROD_W     = SB + TB;
	localparam int ACC_W      = SB + TB + TAP_AW;
	localparam int CHX_W      = (CH_AW > CB) ? CH_AW : CB;
	localparam int TIX_W      = (TAP_AW > IB) ? TAP_AW : IB;

	logic [mcfe_pkg::TAP_COUNT_BITS-1:0]     tap_count_q;
	logic [mcfe_pkg::CHANNEL_COUNT_BITS-1:0] chan_count_q;
	logic [TCNT_W-1:0]                       taps_eff;
	logic [CCNT_W-1:0]                       chans_eff;

	logic                 op_q;
	logic [CB-1:0]        ch_q;
	logic [SB-1:0]        sample_q;
	logic [IB-1:0]        tidx_q;
	logic [TB-1:0]        tval_q;

	logic [CHX_W-1:0]     ch_x;
	logic [CH_AW-1:0]     ch_idx;
	logic [TIX_W-1:0]     tidx_x;
	logic                 tidx_ok;

	logic [TAP_AW-1:0]    hptr_q [MAX_CHANNELS];
	logic [TAP_AW-1:0]    cur_ptr;
	logic [HIST_AW-1:0]   row_base;
	logic [HIST_AW-1:0]   base_q;
	logic [TAP_AW-1:0]    rd_ptr_q;
	logic [TAP_AW-1:0]    k_q;
	logic [HIST_AW-1:0]   clr_q;

	logic [TB-1:0]        tap_mem  [MAX_TAPS];
	logic [SB-1:0]        hist_mem [HIST_DEPTH];

	logic signed [TB-1:0]     tap_rd_s1;
	logic signed [SB-1:0]     hist_rd_s1;
	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;
	logic signed [ACC_W-1:0]  shifted;

	logic                 out_valid_q;
	logic [SB-1:0]        out_filtered_q;
	logic [CB-1:0]        out_channel_q;

	function automatic logic [TAP_AW-1:0] ptr_inc(input logic [TAP_AW-1:0] p);
		logic [TAP_AW-1:0] r;
		if (p == TAP_AW'(MAX_TAPS - 1)) begin
			r = '0;
		end else begin
			r = p + TAP_AW'(1);
		end
		return r;
	endfunction

	function automatic logic [TAP_AW-1:0] ptr_dec(input logic [TAP_AW-1:0] p);
		logic [TAP_AW-1:0] r;
		if (p == '0) begin
			r = TAP_AW'(MAX_TAPS - 1);
		end else begin
			r = p - TAP_AW'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= mcfe_pkg::TAP_COUNT_RESET;
			chan_count_q <= mcfe_pkg::CHANNEL_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mcfe_pkg::REG_TAP_COUNT: begin
					tap_count_q <= cfg_data[mcfe_pkg::TAP_COUNT_BITS-1:0];
				end
				mcfe_pkg::REG_CHANNEL_COUNT: begin
					chan_count_q <= cfg_data[mcfe_pkg::CHANNEL_COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TCNT_W'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = TCNT_W'(MAX_TAPS);
		end else begin
			taps_eff = TCNT_W'(tap_count_q);
		end
		if (chan_count_q == '0) begin
			chans_eff = CCNT_W'(1);
		end else if (32'(chan_count_q) > 32'(MAX_CHANNELS)) begin
			chans_eff = CCNT_W'(MAX_CHANNELS);
		end else begin
			chans_eff = CCNT_W'(chan_count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_opcode;
			ch_q     <= in_channel;
			sample_q <= in_sample;
			tidx_q   <= in_tap_index;
			tval_q   <= in_tap_value;
		end
	end

	assign ch_x     = CHX_W'(ch_q);
	assign ch_idx   = ch_x[CH_AW-1:0];
	assign tidx_x   = TIX_W'(tidx_q);
	assign tidx_ok  = (32'(tidx_q) < 32'(MAX_TAPS));
	assign cur_ptr  = hptr_q[ch_idx];
	assign row_base = HIST_AW'(ch_idx) * HIST_AW'(MAX_TAPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hptr_q[i] <= '0;
			end
			clr_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd.push_write) begin
				hptr_q[ch_idx] <= ptr_inc(cur_ptr);
			end
			if (cmd.clear_en) begin
				clr_q <= clr_q + HIST_AW'(1);
			end
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_write) begin
			k_q      <= '0;
			rd_ptr_q <= cur_ptr;
			base_q   <= row_base;
		end else if (cmd.mac_issue) begin
			k_q      <= k_q + TAP_AW'(1);
			rd_ptr_q <= ptr_dec(rd_ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			if (32'(clr_q) < 32'(MAX_TAPS)) begin
				tap_mem[clr_q[TAP_AW-1:0]] <= '0;
			end
		end else if (cmd.tap_write && tidx_ok) begin
			tap_mem[tidx_x[TAP_AW-1:0]] <= tval_q;
		end
		if (cmd.mac_issue) begin
			tap_rd_s1 <= tap_mem[k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			hist_mem[clr_q] <= '0;
		end else if (cmd.push_write) begin
			hist_mem[row_base + HIST_AW'(cur_ptr)] <= sample_q;
		end
		if (cmd.mac_issue) begin
			hist_rd_s1 <= hist_mem[base_q + HIST_AW'(rd_ptr_q)];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= tap_rd_s1 * hist_rd_s1;
		if (cmd.push_write) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Bias negative sums so the arithmetic shift truncates toward zero
	assign rounded = acc_q + $signed({{(ACC_W - FB){1'b0}}, {FB{acc_q[ACC_W-1]}}});
	assign shifted = rounded >>> FB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_filtered_q <= shifted[SB-1:0];
			out_channel_q  <= ch_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_filtered = out_filtered_q;
	assign out_channel  = out_channel_q;

	assign stat.clear_last = (clr_q == HIST_AW'(HIST_DEPTH - 1));
	assign stat.is_tap     = (op_q == mcfe_pkg::OP_TAP);
	assign stat.chan_ok    = (32'(ch_q) < 32'(chans_eff));
	assign stat.last_issue = (TCNT_W'(k_q) == (taps_eff - TCNT_W'(1)));
	assign stat.pipe_busy  = v_s1 | v_s2;
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

>>> verif/multichannel_fir_equalizer_test.sv
// Self-checking testbench for multichannel_fir_equalizer: directed and random sample pushes and
// coefficient writes under random valid/ready gaps, checked against an in-bench FIR predictor.
// Depends on rtl/mcfe_pkg.sv and rtl/multichannel_fir_equalizer.sv.
`timescale 1ns / 1ps

module multichannel_fir_equalizer_test;

	localparam int CYCLE_LIMIT = 900000;

	typedef struct {
		logic                                    op;
		logic [mcfe_pkg::CHANNEL_BITS-1:0]       channel;
		logic signed [mcfe_pkg::SAMPLE_BITS-1:0] sample;
		logic [mcfe_pkg::TAP_INDEX_BITS-1:0]     tap_index;
		logic signed [mcfe_pkg::TAP_BITS-1:0]    tap_value;
	} eq_req_t;

	typedef struct {
		logic [mcfe_pkg::SAMPLE_BITS-1:0]  filtered;
		logic [mcfe_pkg::CHANNEL_BITS-1:0] channel;
	} eq_out_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   s_axis_tvalid = 1'b0;
	logic                                   s_axis_tready;
	logic [mcfe_pkg::IN_DATA_BITS-1:0]      s_axis_tdata = '0;
	logic                                   s_axis_tuser = 1'b0;
	logic                                   m_axis_tvalid;
	logic                                   m_axis_tready = 1'b0;
	logic [mcfe_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata;
	logic                                   cfg_we = 1'b0;
	logic [mcfe_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
	logic [mcfe_pkg::CFG_DATA_BITS-1:0]     cfg_data = '0;

	multichannel_fir_equalizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state
	logic signed [mcfe_pkg::TAP_BITS-1:0]    tap_mem [mcfe_pkg::MAX_TAPS];
	logic signed [mcfe_pkg::SAMPLE_BITS-1:0] hist_mem [mcfe_pkg::MAX_CHANNELS][mcfe_pkg::MAX_TAPS];
	logic [mcfe_pkg::TAP_INDEX_BITS-1:0]     hist_ptr [mcfe_pkg::MAX_CHANNELS];
	logic [mcfe_pkg::TAP_COUNT_BITS-1:0]     tap_count_reg;
	logic [mcfe_pkg::CHANNEL_COUNT_BITS-1:0] chan_count_reg;

	eq_req_t pending_reqs[$];
	eq_out_t filtered_due[$];
	eq_req_t cur_req;
	int      in_sent = 0;
	int      in_accepted = 0;
	int      cycle_count = 0;
	int      fail_count = 0;
	int      taps_written = 0;
	int      pushes_filtered = 0;
	int      pushes_ignored = 0;
	int      results_checked = 0;
	int      reg_writes = 0;
	bit      steady = 1'b0;

	function automatic int taps_in_use();
		if (tap_count_reg == 0)
			return 1;
		if (tap_count_reg > mcfe_pkg::MAX_TAPS)
			return mcfe_pkg::MAX_TAPS;
		return tap_count_reg;
	endfunction

	function automatic int chans_in_use();
		if (chan_count_reg == 0)
			return 1;
		if (chan_count_reg > mcfe_pkg::MAX_CHANNELS)
			return mcfe_pkg::MAX_CHANNELS;
		return chan_count_reg;
	endfunction

	function automatic logic [23:0] any_word();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
		return 24'($urandom);
	endfunction

	function automatic eq_req_t tap_req(logic [mcfe_pkg::TAP_INDEX_BITS-1:0] idx,
		logic [mcfe_pkg::TAP_BITS-1:0] val);
		eq_req_t r;
		r.op        = mcfe_pkg::OP_TAP;
		r.channel   = mcfe_pkg::CHANNEL_BITS'($urandom);
		r.sample    = any_word();
		r.tap_index = idx;
		r.tap_value = val;
		return r;
	endfunction

	function automatic eq_req_t push_req(logic [mcfe_pkg::CHANNEL_BITS-1:0] ch,
		logic [mcfe_pkg::SAMPLE_BITS-1:0] smp);
		eq_req_t r;
		r.op        = mcfe_pkg::OP_PUSH;
		r.channel   = ch;
		r.sample    = smp;
		r.tap_index = mcfe_pkg::TAP_INDEX_BITS'($urandom);
		r.tap_value = any_word();
		return r;
	endfunction

	function automatic eq_req_t random_req();
		logic [mcfe_pkg::TAP_INDEX_BITS-1:0] idx;
		logic [mcfe_pkg::CHANNEL_BITS-1:0]   ch;
		if ($urandom_range(99) < 25) begin
			idx = ($urandom_range(9) < 7) ? mcfe_pkg::TAP_INDEX_BITS'($urandom_range(63))
				: mcfe_pkg::TAP_INDEX_BITS'($urandom);
			return tap_req(idx, any_word());
		end
		ch = ($urandom_range(99) < 85)
			? mcfe_pkg::CHANNEL_BITS'($urandom_range(chans_in_use() - 1))
			: mcfe_pkg::CHANNEL_BITS'($urandom);
		return push_req(ch, any_word());
	endfunction

	task automatic equalize(input eq_req_t req);
		int                                  taps;
		logic [mcfe_pkg::TAP_INDEX_BITS-1:0] ptr;
		logic signed [63:0]                  acc;
		logic signed [63:0]                  quot;
		eq_out_t                             res;
		if (req.op == mcfe_pkg::OP_TAP) begin
			tap_mem[req.tap_index] = req.tap_value;
			taps_written++;
		end else if (req.channel >= chans_in_use()) begin
			pushes_ignored++;
		end else begin
			taps = taps_in_use();
			ptr = hist_ptr[req.channel];
			hist_mem[req.channel][ptr] = req.sample;
			acc = 0;
			for (int k = 0; k < taps; k++)
				acc += tap_mem[k]
					* hist_mem[req.channel][ptr - mcfe_pkg::TAP_INDEX_BITS'(k)];
			hist_ptr[req.channel] = ptr + 1'b1;
			// truncate toward zero
			if (acc < 0)
				quot = -((-acc) >>> mcfe_pkg::TAP_FRACTION_BITS);
			else
				quot = acc >>> mcfe_pkg::TAP_FRACTION_BITS;
			res.filtered = quot[mcfe_pkg::SAMPLE_BITS-1:0];
			res.channel  = req.channel;
			filtered_due.push_back(res);
			pushes_filtered++;
		end
	endtask

	// wait until every transaction is done, then let the pipeline drain
	task automatic settle();
		while (pending_reqs.size() != 0 || in_accepted != in_sent || filtered_due.size() != 0)
			@(negedge clk);
		repeat (taps_in_use() + 10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [mcfe_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [mcfe_pkg::CFG_DATA_BITS-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == mcfe_pkg::REG_TAP_COUNT)
			tap_count_reg = data[mcfe_pkg::TAP_COUNT_BITS-1:0];
		else
			chan_count_reg = data[mcfe_pkg::CHANNEL_COUNT_BITS-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(negedge clk) begin : sender
		eq_req_t nxt;
		if (!s_axis_tvalid || in_accepted == in_sent) begin
			if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
				nxt = pending_reqs.pop_front();
				cur_req       <= nxt;
				s_axis_tdata  <= {2'b00, nxt.tap_value, nxt.tap_index, nxt.sample, nxt.channel};
				s_axis_tuser  <= nxt.op;
				s_axis_tvalid <= 1'b1;
				in_sent++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 18);

	always @(posedge clk) begin : monitor
		eq_out_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (filtered_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
				fail_count++;
			end else begin
				want = filtered_due.pop_front();
				if (m_axis_tdata[23:0] !== want.filtered) begin
					$display("%0t: filtered mismatch, expected %h, got %h",
						$time, want.filtered, m_axis_tdata[23:0]);
					fail_count++;
				end
				if (m_axis_tdata[26:24] !== want.channel) begin
					$display("%0t: out_channel mismatch, expected %0d, got %0d",
						$time, want.channel, m_axis_tdata[26:24]);
					fail_count++;
				end
				results_checked++;
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			equalize(cur_req);
			in_accepted <= in_accepted + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int taps;
		for (int i = 0; i < mcfe_pkg::MAX_TAPS; i++)
			tap_mem[i] = '0;
		for (int c = 0; c < mcfe_pkg::MAX_CHANNELS; c++) begin
			hist_ptr[c] = '0;
			for (int i = 0; i < mcfe_pkg::MAX_TAPS; i++)
				hist_mem[c][i] = '0;
		end
		tap_count_reg  = mcfe_pkg::TAP_COUNT_RESET;
		chan_count_reg = mcfe_pkg::CHANNEL_COUNT_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-length filter at reset settings
		pending_reqs.push_back(tap_req(11'd0, 24'h7FFFFF));
		pending_reqs.push_back(tap_req(11'd1, 24'h800000));
		pending_reqs.push_back(tap_req(11'd2047, 24'h400000));
		pending_reqs.push_back(tap_req(11'd2046, any_word()));
		pending_reqs.push_back(push_req(3'd0, 24'h7FFFFF));
		pending_reqs.push_back(push_req(3'd1, 24'h800000));
		pending_reqs.push_back(push_req(3'd0, 24'h800000));
		pending_reqs.push_back(push_req(3'd2, any_word()));
		pending_reqs.push_back(push_req(3'd7, any_word()));
		pending_reqs.push_back(push_req(3'd1, 24'h000001));

		// zero counts act as one; negative products round toward zero
		write_reg(mcfe_pkg::REG_TAP_COUNT, 12'd0);
		write_reg(mcfe_pkg::REG_CHANNEL_COUNT, 12'd0);
		pending_reqs.push_back(tap_req(11'd0, 24'hFFFFFF));
		pending_reqs.push_back(push_req(3'd0, 24'h7FFFFF));
		pending_reqs.push_back(push_req(3'd1, any_word()));
		pending_reqs.push_back(push_req(3'd0, 24'h800000));

		// oversized counts saturate; old history reappears
		write_reg(mcfe_pkg::REG_TAP_COUNT, 12'hFFF);
		write_reg(mcfe_pkg::REG_CHANNEL_COUNT, 12'hFFF);
		pending_reqs.push_back(tap_req(11'd0, 24'h400000));
		pending_reqs.push_back(push_req(3'd7, 24'h7FFFFF));
		pending_reqs.push_back(push_req(3'd0, any_word()));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				3:       taps = $urandom_range(100, 300);
				5:       taps = $urandom_range(1500, 4095);
				6:       taps = 0;
				default: taps = $urandom_range(1, 40);
			endcase
			write_reg(mcfe_pkg::REG_TAP_COUNT, mcfe_pkg::CFG_DATA_BITS'(taps));
			write_reg(mcfe_pkg::REG_CHANNEL_COUNT,
				mcfe_pkg::CFG_DATA_BITS'($urandom_range(4095)));
			steady = (ph == 2);
			for (int i = 0; i < 36; i++)
				pending_reqs.push_back(random_req());
			settle();
			steady = 1'b0;
		end

		settle();
		$display("Covered %0d coefficient writes, %0d filtered pushes, %0d ignored pushes,",
			taps_written, pushes_filtered, pushes_ignored);
		$display("%0d register writes and %0d results checked in %0d cycles.",
			reg_writes, results_checked, cycle_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
